[hdl/cpc_pkg.sv]
// Shared constants and types for the constrained path counter.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpc_pkg;

  // Highest height a walk may reach, and the longest walk accepted.
  localparam int MAX_WIDTH = 28;
  // Number of positions described by the fixed and occupied masks.
  localparam int MASK_BITS = 28;
  // Width of the path_width field on the input port.
  localparam int PATH_W    = 5;
  // Width of a path count; counts saturate at the all-ones value.
  localparam int CNT_W     = 29;
  // Position counter width: it must hold every value from 0 to MAX_WIDTH.
  localparam int POS_W     = $clog2(MAX_WIDTH + 1);
  // Sum of three counts before saturation.
  localparam int SUM_W     = CNT_W + 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef logic [CNT_W-1:0] count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new word and reset the height counts
    logic step;   // advance the walk by one position
    logic emit;   // capture the count at height one as the result
  } cpc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;  // every position of the walk has been taken
  } cpc_stat_t;

endpackage

`default_nettype wire

[hdl/cpc_dp.sv]
// Datapath: holds the count of walks at every height and advances them all
// one position per step. Depends on cpc_pkg.
`default_nettype none

module cpc_dp
  import cpc_pkg::*;
(
  input  wire logic                 clk,
  input  wire cpc_cmd_t             cmd,
  output cpc_stat_t                 stat,
  input  wire logic [PATH_W-1:0]    in_path_width,
  input  wire logic [MASK_BITS-1:0] in_fixed_mask,
  input  wire logic [MASK_BITS-1:0] in_occupied_mask,
  output count_t                    out_path_count
);

  count_t                 cur_r   [MAX_WIDTH+1];
  count_t                 cur_nxt [MAX_WIDTH+1];
  logic [MASK_BITS-1:0]   fixed_r;
  logic [MASK_BITS-1:0]   occ_r;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       width_r;
  logic [POS_W-1:0]       width_clamped;
  count_t                 out_count_r;
  logic                   keep;
  logic                   move;

  always_comb begin
    if (in_path_width > PATH_W'(MAX_WIDTH)) begin
      width_clamped = POS_W'(MAX_WIDTH);
    end else begin
      width_clamped = POS_W'(in_path_width);
    end
  end

  // The masks shift right once per position, so bit 0 always describes the
  // current position; positions past the mask see zeros and are free.
  assign keep = !fixed_r[0] || !occ_r[0];
  assign move = !fixed_r[0] ||  occ_r[0];

  for (genvar h = 0; h <= MAX_WIDTH; h++) begin : g_height
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] below;
    logic [SUM_W-1:0] above;

    if (h == 0) begin : g_floor
      assign below = '0;
    end else begin : g_mid_lo
      assign below = SUM_W'(cur_r[h-1]);
    end

    if (h == MAX_WIDTH) begin : g_ceiling
      assign above = '0;
    end else begin : g_mid_hi
      assign above = SUM_W'(cur_r[h+1]);
    end

    // Saturating sums stay exact below the limit, so the final count is
    // the true count clamped to the limit.
    assign sum = (keep ? SUM_W'(cur_r[h]) : '0) + (move ? below + above : '0);
    assign cur_nxt[h] = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int h = 0; h <= MAX_WIDTH; h++) begin
        cur_r[h] <= (h == 0) ? count_t'(1) : '0;
      end
      fixed_r <= in_fixed_mask;
      occ_r   <= in_occupied_mask;
      pos_r   <= '0;
      width_r <= width_clamped;
    end else if (cmd.step) begin
      cur_r   <= cur_nxt;
      fixed_r <= fixed_r >> 1;
      occ_r   <= occ_r >> 1;
      pos_r   <= pos_r + POS_W'(1);
    end
    if (cmd.emit) begin
      out_count_r <= cur_r[1];
    end
  end

  assign stat.walk_done  = (pos_r == width_r);
  assign out_path_count  = out_count_r;

  a_step_in_range: assert property (@(posedge clk) cmd.step |-> !stat.walk_done)
    else $error("step issued after the last position");
  a_no_load_and_step: assert property (@(posedge clk) cmd.load |-> !cmd.step)
    else $error("load and step issued together");
  a_emit_captures: assert property (@(posedge clk) cmd.emit |=> out_count_r == $past(cur_r[1]))
    else $error("result register missed the count at height one");

endmodule

`default_nettype wire

[hdl/cpc_ctrl.sv]
// Controller: sequences load, one step per position and the result strobe.
// Depends on cpc_pkg.
`default_nettype none

module cpc_ctrl
  import cpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  output cpc_cmd_t       cmd,
  input  wire cpc_stat_t stat,
  output logic           out_valid
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (stat.walk_done) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_valid_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r |-> state_r == ST_IDLE)
    else $error("result strobe raised while a walk is in progress");
  a_load_enters_walk: assert property (@(posedge clk) disable iff (!rst_n)
      cmd.load |=> state_r == ST_WALK)
    else $error("accepted word did not start a walk");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

[hdl/constrained_path_counter.sv]
// Top level of the constrained path counter: joins controller and datapath.
// Depends on cpc_pkg, cpc_ctrl and cpc_dp.
// Sequence: a word is taken when start is high and the block is idle; then one
// step per position (path_width after clamping to 28, none for width zero), then
// the emit, from which the strobe is registered. A new word waits for idle; the
// height array advances one position per cycle with all heights updated together.
// Reset: rst_n is synchronous and active low; it returns the controller to
// idle and clears the strobe. The receiver cannot stall the result.
`default_nettype none

module constrained_path_counter
  import cpc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [PATH_W-1:0]    in_path_width,
  input  wire logic [MASK_BITS-1:0] in_fixed_mask,
  input  wire logic [MASK_BITS-1:0] in_occupied_mask,
  output logic                      out_valid,
  output logic [CNT_W-1:0]          out_path_count
);

  // The controller and datapath talk only through these two bundles.
  cpc_cmd_t  cmd;
  cpc_stat_t stat;

  // The controller takes a word when start is high and it is idle, then
  // steps the datapath once per position until the walk is complete, and
  // finally raises the result strobe for a single cycle. It is idle again
  // in the strobe cycle, so the next word can be taken at that point.
  cpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid)
  );

  // The datapath keeps a saturating count of walks for every height. At each
  // position the forced and occupied bits decide whether walks may stay
  // level, step, or both, and all heights are updated in the same cycle.
  // The result register is separate from the height array, so a new word
  // may be loaded while the previous result is still on the output.
  cpc_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .stat             (stat),
    .in_path_width    (in_path_width),
    .in_fixed_mask    (in_fixed_mask),
    .in_occupied_mask (in_occupied_mask),
    .out_path_count   (out_path_count)
  );

endmodule

`default_nettype wire

[bench/constrained_path_counter_tb.sv]
// Self-checking testbench for the constrained path counter top level.
// Depends on cpc_pkg and on the RTL of constrained_path_counter; nothing else.
`default_nettype none

module constrained_path_counter_tb;
  import cpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run control. The slowest correct run is about 1100 words of the longest walk, each
  // followed by the longest sender gap; the limit is several times that.
  localparam int RANDOM_WORDS = 1050;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 4 * (MAX_WIDTH + 2);
  localparam int MAX_REPORTS  = 30;

  localparam logic [MASK_BITS-1:0] ALL_SET = '1;

  // One row of the directed table. Where known is set, the expected count is typed in
  // beside the word; otherwise the predictor works it out.
  typedef struct packed {
    logic [PATH_W-1:0]    width;
    logic [MASK_BITS-1:0] fixed;
    logic [MASK_BITS-1:0] occ;
    logic                 known;
    count_t               count;
  } path_row_t;

  // A word accepted by the block, with the count it should give.
  typedef struct {
    logic [PATH_W-1:0]    width;
    logic [MASK_BITS-1:0] fixed;
    logic [MASK_BITS-1:0] occ;
    count_t               count;
  } expected_word_t;

  localparam int DIR_ROWS = 25;
  localparam path_row_t DIRECTED [DIR_ROWS] = '{
    // Zero width: nothing is walked, so the walk ends at height 0.
    '{5'd0,  28'h0000000, 28'h0000000, 1'b1, 29'd0},
    '{5'd0,  ALL_SET,     ALL_SET,     1'b1, 29'd0},
    // A single free position: only the step up reaches height 1.
    '{5'd1,  28'h0000000, 28'h0000000, 1'b1, 29'd1},
    // The occupied bit has no effect at a free position.
    '{5'd1,  28'h0000000, ALL_SET,     1'b1, 29'd1},
    // Forced level at the only position leaves the walk at 0.
    '{5'd1,  28'h0000001, 28'h0000000, 1'b1, 29'd0},
    // Forced step at the only position: up is the only legal move.
    '{5'd1,  28'h0000001, 28'h0000001, 1'b1, 29'd1},
    // Mask bits above the width do not matter.
    '{5'd1,  28'hFFFFFFE, 28'h0000000, 1'b1, 29'd1},
    // Two free positions: up then level, or level then up.
    '{5'd2,  28'h0000000, 28'h0000000, 1'b1, 29'd2},
    // Full width and all free: the count saturates.
    '{5'd28, 28'h0000000, 28'h0000000, 1'b1, COUNT_MAX},
    // Width beyond the maximum is clamped to the maximum, so it saturates too.
    '{5'd31, 28'h0000000, 28'h0000000, 1'b1, COUNT_MAX},
    // An even number of forced steps can never end at an odd height.
    '{5'd28, ALL_SET,     ALL_SET,     1'b1, 29'd0},
    // Width 29 would give an odd number of steps; clamped to 28 it stays even.
    '{5'd29, ALL_SET,     ALL_SET,     1'b1, 29'd0},
    '{5'd31, ALL_SET,     ALL_SET,     1'b1, 29'd0},
    // Every position forced level: the walk never leaves 0.
    '{5'd28, ALL_SET,     28'h0000000, 1'b1, 29'd0},
    '{5'd31, ALL_SET,     28'h0000000, 1'b1, 29'd0},
    // The rows below are left to the predictor.
    '{5'd27, ALL_SET,     ALL_SET,     1'b0, 29'd0},
    '{5'd28, 28'hFFFFFFE, ALL_SET,     1'b0, 29'd0},
    '{5'd28, 28'hAAAAAAA, ALL_SET,     1'b0, 29'd0},
    '{5'd28, 28'h5555555, 28'h0000000, 1'b0, 29'd0},
    '{5'd20, 28'h00FF00F, 28'h0F0F0F0, 1'b0, 29'd0},
    '{5'd28, 28'h8000000, 28'h8000000, 1'b0, 29'd0},
    '{5'd28, 28'h8000000, 28'h0000000, 1'b0, 29'd0},
    '{5'd16, 28'hFFF0000, 28'h0000000, 1'b0, 29'd0},
    '{5'd22, 28'h0000000, 28'h0000000, 1'b0, 29'd0},
    '{5'd23, 28'h0000000, 28'h0000000, 1'b0, 29'd0}
  };

  // Clock, reset and the ports of the block. Everything starts at a known value.
  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 start            = 1'b0;
  logic [PATH_W-1:0]    in_path_width    = '0;
  logic [MASK_BITS-1:0] in_fixed_mask    = '0;
  logic [MASK_BITS-1:0] in_occupied_mask = '0;
  logic                 busy;
  logic                 out_valid;
  count_t               out_path_count;

  // Typed-in expectation that travels alongside the word on the input ports.
  logic                 word_known       = 1'b0;
  count_t               word_count       = '0;

  expected_word_t pending_counts [$];
  int failures      = 0;
  int reports       = 0;
  int checked_words = 0;
  int saturated     = 0;
  int zero_counts   = 0;
  int odd_widths    = 0;
  int cycle_count   = 0;

  constrained_path_counter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_path_width    (in_path_width),
    .in_fixed_mask    (in_fixed_mask),
    .in_occupied_mask (in_occupied_mask),
    .out_valid        (out_valid),
    .out_path_count   (out_path_count)
  );

  // 4 ns clock period.
  always #2 clk = ~clk;

  // Predictor: walks the heights position by position, exactly as the block does in
  // parallel, using 64-bit counts so that saturation can be applied at the end.
  function automatic count_t predict_count(input logic [PATH_W-1:0] width,
                                           input logic [MASK_BITS-1:0] fixed,
                                           input logic [MASK_BITS-1:0] occ);
    longint unsigned heights [MAX_WIDTH+2];
    longint unsigned next_heights [MAX_WIDTH+2];
    longint unsigned acc;
    int  steps;
    bit  forced;
    bit  stepping;
    steps = (int'(width) > MAX_WIDTH) ? MAX_WIDTH : int'(width);
    for (int h = 0; h < MAX_WIDTH + 2; h++) heights[h] = 0;
    heights[0] = 1;
    for (int p = 0; p < steps; p++) begin
      // Positions past the masks are free.
      forced   = (p < MASK_BITS) ? fixed[p] : 1'b0;
      stepping = (p < MASK_BITS) ? occ[p] : 1'b0;
      for (int h = 0; h <= MAX_WIDTH; h++) begin
        acc = 0;
        if (!forced || !stepping) acc += heights[h];
        if (!forced || stepping) begin
          if (h > 0) acc += heights[h-1];
          acc += heights[h+1];
        end
        next_heights[h] = acc;
      end
      next_heights[MAX_WIDTH+1] = 0;
      heights = next_heights;
    end
    if (heights[1] > longint'(COUNT_MAX)) return COUNT_MAX;
    return count_t'(heights[1]);
  endfunction

  // Offers one word and holds it until the block takes it. The word is accepted at the
  // first rising edge at which start is high and busy is low; busy is sampled before the
  // block updates it at that edge.
  task automatic send_word(input logic [PATH_W-1:0] width,
                           input logic [MASK_BITS-1:0] fixed,
                           input logic [MASK_BITS-1:0] occ,
                           input logic known,
                           input count_t count);
    start            <= 1'b1;
    in_path_width    <= width;
    in_fixed_mask    <= fixed;
    in_occupied_mask <= occ;
    word_known       <= known;
    word_count       <= count;
    do @(posedge clk); while (busy);
  endtask

  // Sender idles for a number of cycles, with noise on the data ports that the block
  // must ignore while start is low.
  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    for (int i = 0; i < cycles; i++) begin
      in_path_width    <= PATH_W'($urandom);
      in_fixed_mask    <= MASK_BITS'($urandom);
      in_occupied_mask <= MASK_BITS'($urandom);
      @(posedge clk);
    end
  endtask

  // Scoreboard. Results are compared before the word accepted at the same edge is
  // recorded, so the order of the two is fixed within one process.
  always @(posedge clk) begin
    expected_word_t oldest;
    expected_word_t taken;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_counts.size() == 0) begin
          failures++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t ERROR result with no word outstanding: expected none, actual %0d",
                     $time, out_path_count);
          end
        end else begin
          oldest = pending_counts.pop_front();
          checked_words++;
          if (out_path_count !== oldest.count) begin
            failures++;
            if (reports < MAX_REPORTS) begin
              reports++;
              $display("%0t ERROR path_count width=%0d fixed=%h occupied=%h: expected %0d, actual %0d",
                       $time, oldest.width, oldest.fixed, oldest.occ, oldest.count,
                       out_path_count);
            end
          end
        end
      end
      if (start && !busy) begin
        taken.width = in_path_width;
        taken.fixed = in_fixed_mask;
        taken.occ   = in_occupied_mask;
        taken.count = word_known ? word_count
                                 : predict_count(in_path_width, in_fixed_mask, in_occupied_mask);
        if (taken.count == COUNT_MAX) saturated++;
        if (taken.count == '0) zero_counts++;
        if (in_path_width == '0 || int'(in_path_width) > MAX_WIDTH) odd_widths++;
        pending_counts = {pending_counts, taken};
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t ERROR run exceeded %0d cycles", $time, LIMIT_CYCLES);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    logic [PATH_W-1:0]    width;
    logic [MASK_BITS-1:0] fixed;
    logic [MASK_BITS-1:0] occ;
    int burst_left;
    int drained;

    // Reset held low from the start, then released at a rising edge.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with short random gaps so that some words go back to back.
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_word(DIRECTED[r].width, DIRECTED[r].fixed, DIRECTED[r].occ,
                DIRECTED[r].known, DIRECTED[r].count);
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 4));
    end

    // Random words in bursts. Free or sparsely fixed masks dominate, since densely fixed
    // masks with random occupied bits mostly give a count of zero.
    burst_left = $urandom_range(1, 12);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      case ($urandom_range(0, 19)) inside
        0:       width = '0;
        1:       width = PATH_W'($urandom_range(MAX_WIDTH + 1, (1 << PATH_W) - 1));
        [2:4]:   width = PATH_W'(MAX_WIDTH);
        default: width = PATH_W'($urandom_range(1, MAX_WIDTH - 1));
      endcase
      case ($urandom_range(0, 9)) inside
        [0:2]:   fixed = '0;
        [3:5]:   fixed = MASK_BITS'($urandom & $urandom & $urandom);
        [6:7]:   fixed = MASK_BITS'($urandom);
        8:       fixed = MASK_BITS'($urandom | $urandom);
        default: fixed = ALL_SET;
      endcase
      case ($urandom_range(0, 3))
        // Forced steps only, which keeps some paths alive through fixed stretches.
        0:       occ = fixed | MASK_BITS'($urandom);
        // Forced levels only.
        1:       occ = ~fixed & MASK_BITS'($urandom);
        default: occ = MASK_BITS'($urandom);
      endcase
      send_word(width, fixed, occ, 1'b0, '0);
      burst_left--;
      if (burst_left == 0) begin
        // Gaps range over the whole length of a walk so that they meet every phase of it;
        // now and then a long burst gives a stretch with no idling at all.
        idle_gap($urandom_range(1, 35));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
      end
    end
    idle_gap(1);

    // Wait for every outstanding count, then a little longer for any stray strobe.
    drained = 0;
    while (pending_counts.size() != 0 && drained < 20 * DRAIN_CYCLES) begin
      @(posedge clk);
      drained++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_counts.size() != 0) begin
      failures += pending_counts.size();
      $display("%0t ERROR %0d words never gave a result: expected %0d, actual 0",
               $time, pending_counts.size(), pending_counts.size());
    end

    $display("Checked %0d counts over directed and random words in %0d cycles.",
             checked_words, cycle_count);
    $display("Among them %0d saturated, %0d zero and %0d with zero or clamped width.",
             saturated, zero_counts, odd_widths);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hdl/cpc_pkg.sv
hdl/cpc_dp.sv
hdl/cpc_ctrl.sv
hdl/constrained_path_counter.sv
bench/constrained_path_counter_tb.sv
